/* rtl/core/i2cm_pkg.sv */
`default_nettype none

package i2cm_pkg;

   // Command codes carried in the request tuser field.
   localparam logic [2:0] REQ_NONE  = 3'd0;
   localparam logic [2:0] REQ_START = 3'd1;
   localparam logic [2:0] REQ_STOP  = 3'd2;
   localparam logic [2:0] REQ_WRITE = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_POLL_LIMIT  = 1'b1;

   // Register reset values.
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd12;
   localparam logic [7:0]  POLL_LIMIT_RESET  = 8'd255;

   // Widths of the packed stream payloads.
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;

   // One accepted request item: one bus tick.
   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] write_byte;
      logic       read_ack;
      logic       sda_in;
   } i2cm_item_type;

   // One result item: the pin levels and status after the tick.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] read_data;
   } i2cm_result_type;

   // Configuration values seen by the engine.
   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [7:0]  ack_poll_limit;
   } i2cm_cfg_type;

endpackage

`default_nettype wire

/* rtl/core/i2c_master_bit_engine_unit.sv */
`default_nettype none

// Channel  Dir  Ports                     Contents
// req      in   req_tvalid/tready/tdata   one bus tick: write_byte, read_ack, sda_in
//                req_tuser                 req_type
// rsp      out  rsp_tvalid/tready/tdata   pins and status after that tick
// csr      in   csr_we/index/wdata        phase_ticks (0), ack_poll_limit (1)
//
// Each item goes through an input register, the engine logic and an output
// register; one item per cycle is sustained while rsp is not stalled.
// The engine state update, done once per item, sets the rate.
// Reset is synchronous; afterwards the bus is idle with SCL and SDA high.
// A stall on rsp holds the result; req then takes an item into its
// register only while that register is empty, and stalls otherwise.

module i2c_master_bit_engine_unit
   import i2cm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] write_byte, [8] read_ack, [9] sda_in, [15:10] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] req_type
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
   // [5] ack_ok, [13:6] read_data, [15:14] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [15:0]           csr_wdata
);

   i2cm_cfg_type    cfg_ff;
   i2cm_item_type   item_ff, item_in;
   logic            item_valid_ff;
   i2cm_result_type result_ff, result_in;
   logic            rsp_valid_ff;
   logic            out_ready;
   logic            step_en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks    <= PHASE_TICKS_RESET;
         cfg_ff.ack_poll_limit <= POLL_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_TICKS: cfg_ff.phase_ticks    <= csr_wdata;
            CSR_POLL_LIMIT:  cfg_ff.ack_poll_limit <= csr_wdata[7:0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Handshake: the engine steps when an item waits and the output can load.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign step_en    = item_valid_ff && out_ready;
   assign req_tready = !item_valid_ff || out_ready;

   assign item_in.req_type   = req_tuser;
   assign item_in.write_byte = req_tdata[7:0];
   assign item_in.read_ack   = req_tdata[8];
   assign item_in.sda_in     = req_tdata[9];

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   i2cm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result_in)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff.read_data, result_ff.ack_ok, result_ff.done_res,
                        result_ff.busy_res, result_ff.sda_drive, result_ff.sda_out,
                        result_ff.scl_out};

   // A processed item always reaches the output register.
   a_step_loads: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("processed item did not reach the output register");

   // A waiting item is never dropped while the output stalls.
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !step_en |=> item_valid_ff)
      else $error("waiting item lost");

   // Ack and read data appear only with the completion pulse.
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.done_res |-> !result_ff.ack_ok && result_ff.read_data == 8'd0)
      else $error("completion fields without done");

   // A completing command always leaves the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.done_res |-> !result_ff.busy_res)
      else $error("done while still busy");

endmodule

`default_nettype wire

/* rtl/core/i2cm_core.sv */
`default_nettype none

module i2cm_core
   import i2cm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire i2cm_item_type   item,
   input  wire i2cm_cfg_type    cfg,
   output i2cm_result_type      result
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_STOP,
      ST_WRITE,
      ST_READ
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] delay_ff, delay_in;
   logic [7:0]  poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_lvl_in;
   logic        dir_ff, dir_in;
   logic        ack_seen_ff, ack_seen_in;
   logic        ack_mode_ff, ack_mode_in;

   // Next state for one tick: command launch, phase delay, phase advance,
   // then the pin actions of the phase that is entered.
   always_comb begin
      logic enter;
      logic done;
      enter       = 1'b0;
      done        = 1'b0;
      state_in    = state_ff;
      phase_in    = phase_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      delay_in    = delay_ff;
      poll_in     = poll_ff;
      scl_in      = scl_ff;
      sda_lvl_in  = sda_ff;
      dir_in      = dir_ff;
      ack_seen_in = ack_seen_ff;
      ack_mode_in = ack_mode_ff;
      result      = '0;

      if (state_ff == ST_IDLE) begin
         enter    = 1'b1;
         phase_in = 3'd0;
         bits_in  = 4'd0;
         case (item.req_type)
            REQ_START: state_in = ST_START;
            REQ_STOP:  state_in = ST_STOP;
            REQ_WRITE: begin
               state_in    = ST_WRITE;
               shift_in    = item.write_byte;
               ack_seen_in = 1'b0;
            end
            REQ_READ: begin
               state_in    = ST_READ;
               shift_in    = 8'd0;
               ack_mode_in = item.read_ack;
            end
            default: begin
               enter    = 1'b0;
               phase_in = phase_ff;
               bits_in  = bits_ff;
            end
         endcase
      end else if (delay_ff != 16'd0) begin
         delay_in = delay_ff - 16'd1;
      end else begin
         // The current phase has run out: move to the next one.
         enter = 1'b1;
         case (state_ff)
            ST_START: begin
               if (phase_ff >= 3'd2) done = 1'b1;
               else phase_in = phase_ff + 3'd1;
            end
            ST_STOP: begin
               if (phase_ff >= 3'd3) done = 1'b1;
               else phase_in = phase_ff + 3'd1;
            end
            ST_WRITE: begin
               if (phase_ff == 3'd2) begin
                  bits_in  = bits_ff + 4'd1;
                  phase_in = (bits_in < 4'd8) ? 3'd0 : 3'd3;
               end else if (phase_ff == 3'd5) begin
                  phase_in = phase_ff;
               end else if (phase_ff >= 3'd7) begin
                  done = 1'b1;
               end else begin
                  phase_in = phase_ff + 3'd1;
               end
            end
            ST_READ: begin
               if (phase_ff == 3'd1) begin
                  shift_in = {shift_ff[6:0], item.sda_in};
                  bits_in  = bits_ff + 4'd1;
                  phase_in = (bits_in < 4'd8) ? 3'd0 : 3'd2;
               end else if (phase_ff >= 3'd4) begin
                  done = 1'b1;
               end else begin
                  phase_in = phase_ff + 3'd1;
               end
            end
            default: done = 1'b1;
         endcase
         if (done) begin
            enter           = 1'b0;
            result.done_res = 1'b1;
            if (state_ff == ST_WRITE) result.ack_ok = ack_seen_ff;
            if (state_ff == ST_READ) result.read_data = shift_ff;
            state_in = ST_IDLE;
            phase_in = 3'd0;
         end
      end

      // Pin actions of the phase being entered, and its delay.
      if (enter) begin
         case (state_in)
            ST_START: begin
               if (phase_in == 3'd0) begin
                  dir_in     = 1'b1;
                  sda_lvl_in = 1'b1;
               end else if (phase_in == 3'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_lvl_in = 1'b0;
               end
            end
            ST_STOP: begin
               if (phase_in == 3'd0) scl_in = 1'b0;
               else if (phase_in == 3'd1) sda_lvl_in = 1'b0;
               else if (phase_in == 3'd2) scl_in = 1'b1;
               else sda_lvl_in = 1'b1;
            end
            ST_WRITE: begin
               case (phase_in)
                  3'd0: scl_in = 1'b0;
                  3'd1: begin
                     sda_lvl_in = shift_in[7];
                     shift_in   = {shift_in[6:0], 1'b0};
                  end
                  3'd2: scl_in = 1'b1;
                  3'd3: scl_in = 1'b0;
                  3'd4: begin
                     dir_in  = 1'b0;
                     scl_in  = 1'b1;
                     poll_in = cfg.ack_poll_limit;
                  end
                  3'd5: begin
                     // Low SDA is an ack; each high sample uses up one poll.
                     if (!item.sda_in) begin
                        ack_seen_in = 1'b1;
                        phase_in    = 3'd6;
                        scl_in      = 1'b0;
                     end else begin
                        poll_in = poll_in - 8'd1;
                        if (poll_in == 8'd0) begin
                           ack_seen_in = 1'b0;
                           phase_in    = 3'd6;
                           scl_in      = 1'b0;
                        end
                     end
                  end
                  3'd6: scl_in = 1'b0;
                  default: dir_in = 1'b1;
               endcase
            end
            ST_READ: begin
               if (phase_in == 3'd0) begin
                  scl_in = 1'b0;
                  dir_in = 1'b0;
               end else if (phase_in == 3'd1) begin
                  scl_in = 1'b1;
               end else if (phase_in == 3'd2) begin
                  scl_in = 1'b0;
               end else if (phase_in == 3'd3) begin
                  dir_in     = 1'b1;
                  sda_lvl_in = !ack_mode_in;
               end else begin
                  scl_in = 1'b1;
               end
            end
            default: scl_in = scl_in;
         endcase
         delay_in = (cfg.phase_ticks == 16'd0) ? 16'd0 : cfg.phase_ticks - 16'd1;
      end

      result.scl_out   = scl_in;
      result.sda_out   = sda_lvl_in;
      result.sda_drive = dir_in;
      result.busy_res  = (state_in != ST_IDLE);
   end

   // Engine state advances once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= 3'd0;
         bits_ff     <= 4'd0;
         shift_ff    <= 8'd0;
         delay_ff    <= 16'd0;
         poll_ff     <= 8'd0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         dir_ff      <= 1'b1;
         ack_seen_ff <= 1'b0;
         ack_mode_ff <= 1'b0;
      end else if (step_en) begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         bits_ff     <= bits_in;
         shift_ff    <= shift_in;
         delay_ff    <= delay_in;
         poll_ff     <= poll_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_lvl_in;
         dir_ff      <= dir_in;
         ack_seen_ff <= ack_seen_in;
         ack_mode_ff <= ack_mode_in;
      end
   end

endmodule

`default_nettype wire

/* dv/i2c_master_bit_engine_checker.sv */
// Watches the request, result and register-write ports of the bit engine.
// It runs its own model of the engine on every accepted item and compares
// each accepted result with the oldest prediction.
module i2c_master_bit_engine_checker
   import i2cm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // [7:0] write_byte, [8] read_ack, [9] sda_in, [15:10] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] req_type
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
   // [5] ack_ok, [13:6] read_data, [15:14] zero
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [15:0]           csr_wdata,
   output int                         mismatch_count,
   output int                         pending_count
);

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_START,
      ENG_STOP,
      ENG_WRITE,
      ENG_READ
   } eng_state_type;

   // Register copies.
   logic [15:0] cfg_ticks;
   logic [7:0]  cfg_poll_limit;

   // Engine copy.
   eng_state_type eng;
   logic [2:0]    step;
   logic [3:0]    bits_done;
   logic [7:0]    shreg;
   logic [15:0]   dly;
   logic [7:0]    polls_left;
   logic          scl_q;
   logic          sda_q;
   logic          drv_q;
   logic          ack_got;
   logic          ack_send;

   i2cm_result_type expected_pins[$];

   // Applies the pin changes of the phase just entered and starts its delay.
   function void enter_phase(input logic sda_bit);
      case (eng)
         ENG_START: begin
            if (step == 3'd0) begin
               drv_q = 1'b1;
               sda_q = 1'b1;
            end else if (step == 3'd1) begin
               scl_q = 1'b1;
            end else begin
               sda_q = 1'b0;
            end
         end
         ENG_STOP: begin
            if (step == 3'd0) scl_q = 1'b0;
            else if (step == 3'd1) sda_q = 1'b0;
            else if (step == 3'd2) scl_q = 1'b1;
            else sda_q = 1'b1;
         end
         ENG_WRITE: begin
            case (step)
               3'd0: scl_q = 1'b0;
               3'd1: begin
                  sda_q = shreg[7];
                  shreg = {shreg[6:0], 1'b0};
               end
               3'd2: scl_q = 1'b1;
               3'd3: scl_q = 1'b0;
               3'd4: begin
                  drv_q = 1'b0;
                  scl_q = 1'b1;
                  polls_left = cfg_poll_limit;
               end
               3'd5: begin
                  // A low sample is an ack; otherwise count one poll down.
                  if (!sda_bit) begin
                     ack_got = 1'b1;
                     step = 3'd6;
                     scl_q = 1'b0;
                  end else begin
                     polls_left = polls_left - 8'd1;
                     if (polls_left == 8'd0) begin
                        ack_got = 1'b0;
                        step = 3'd6;
                        scl_q = 1'b0;
                     end
                  end
               end
               3'd6: scl_q = 1'b0;
               default: drv_q = 1'b1;
            endcase
         end
         ENG_READ: begin
            if (step == 3'd0) begin
               scl_q = 1'b0;
               drv_q = 1'b0;
            end else if (step == 3'd1) begin
               scl_q = 1'b1;
            end else if (step == 3'd2) begin
               scl_q = 1'b0;
            end else if (step == 3'd3) begin
               drv_q = 1'b1;
               sda_q = !ack_send;
            end else begin
               scl_q = 1'b1;
            end
         end
         default: ;
      endcase
      dly = (cfg_ticks == 16'd0) ? 16'd0 : cfg_ticks - 16'd1;
   endfunction

   // Advances the engine by one tick and returns the pins and status after it.
   function i2cm_result_type bus_tick(input i2cm_item_type it);
      i2cm_result_type r;
      logic            finished;
      r = '0;
      finished = 1'b0;
      if (eng == ENG_IDLE) begin
         case (it.req_type)
            REQ_START: eng = ENG_START;
            REQ_STOP:  eng = ENG_STOP;
            REQ_WRITE: eng = ENG_WRITE;
            REQ_READ:  eng = ENG_READ;
            default: ;
         endcase
         if (eng != ENG_IDLE) begin
            step = 3'd0;
            bits_done = 4'd0;
            if (eng == ENG_WRITE) begin
               shreg = it.write_byte;
               ack_got = 1'b0;
            end
            if (eng == ENG_READ) begin
               shreg = 8'd0;
               ack_send = it.read_ack;
            end
            enter_phase(it.sda_in);
         end
      end else if (dly != 16'd0) begin
         dly = dly - 16'd1;
      end else begin
         // The current phase has run out: move to the next one or finish.
         case (eng)
            ENG_START, ENG_STOP: begin
               if (step >= ((eng == ENG_START) ? 3'd2 : 3'd3)) finished = 1'b1;
               else step = step + 3'd1;
            end
            ENG_WRITE: begin
               if (step == 3'd2) begin
                  bits_done = bits_done + 4'd1;
                  step = (bits_done < 4'd8) ? 3'd0 : 3'd3;
               end else if (step >= 3'd7) begin
                  finished = 1'b1;
               end else if (step != 3'd5) begin
                  step = step + 3'd1;
               end
            end
            ENG_READ: begin
               if (step == 3'd1) begin
                  shreg = {shreg[6:0], it.sda_in};
                  bits_done = bits_done + 4'd1;
                  step = (bits_done < 4'd8) ? 3'd0 : 3'd2;
               end else if (step >= 3'd4) begin
                  finished = 1'b1;
               end else begin
                  step = step + 3'd1;
               end
            end
            default: finished = 1'b1;
         endcase
         if (finished) begin
            r.done_res = 1'b1;
            if (eng == ENG_WRITE) r.ack_ok = ack_got;
            if (eng == ENG_READ) r.read_data = shreg;
            eng = ENG_IDLE;
            step = 3'd0;
         end else begin
            enter_phase(it.sda_in);
         end
      end
      r.scl_out = scl_q;
      r.sda_out = sda_q;
      r.sda_drive = drv_q;
      r.busy_res = (eng != ENG_IDLE);
      return r;
   endfunction

   // Track register writes, compare results and predict new ones.
   always @(posedge clock) begin
      i2cm_item_type   it;
      i2cm_result_type got;
      i2cm_result_type exp_r;
      if (reset) begin
         cfg_ticks = PHASE_TICKS_RESET;
         cfg_poll_limit = POLL_LIMIT_RESET;
         eng = ENG_IDLE;
         step = 3'd0;
         bits_done = 4'd0;
         shreg = 8'd0;
         dly = 16'd0;
         polls_left = 8'd0;
         scl_q = 1'b1;
         sda_q = 1'b1;
         drv_q = 1'b1;
         ack_got = 1'b0;
         ack_send = 1'b0;
         expected_pins.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PHASE_TICKS: cfg_ticks = csr_wdata;
               CSR_POLL_LIMIT:  cfg_poll_limit = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.scl_out = rsp_tdata[0];
            got.sda_out = rsp_tdata[1];
            got.sda_drive = rsp_tdata[2];
            got.busy_res = rsp_tdata[3];
            got.done_res = rsp_tdata[4];
            got.ack_ok = rsp_tdata[5];
            got.read_data = rsp_tdata[13:6];
            if (expected_pins.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               exp_r = expected_pins.pop_front();
               if (got !== exp_r) begin
                  mismatch_count++;
                  $display({"%0t: result mismatch, expected scl=%b sda=%b drive=%b busy=%b",
                            " done=%b ack=%b data=%h, actual scl=%b sda=%b drive=%b",
                            " busy=%b done=%b ack=%b data=%h"}, $time,
                           exp_r.scl_out, exp_r.sda_out, exp_r.sda_drive,
                           exp_r.busy_res, exp_r.done_res, exp_r.ack_ok,
                           exp_r.read_data, got.scl_out, got.sda_out, got.sda_drive,
                           got.busy_res, got.done_res, got.ack_ok, got.read_data);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            it.req_type = req_tuser;
            it.write_byte = req_tdata[7:0];
            it.read_ack = req_tdata[8];
            it.sda_in = req_tdata[9];
            expected_pins.push_back(bus_tick(it));
         end
      end
      pending_count = expected_pins.size();
   end

endmodule

/* dv/tb_i2c_master_bit_engine_unit.sv */
module tb_i2c_master_bit_engine_unit;
   import i2cm_pkg::*;

   // Request codes the engine must ignore.
   localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
   localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = REQ_NONE;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_PHASE_TICKS;
   logic [15:0]           csr_wdata = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   bit idling = 1'b1;
   int sink_stall = 0;
   int mismatch_count;
   int pending_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   i2c_master_bit_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   i2c_master_bit_engine_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Result side: ready, with random stall bursts while idling is set.
   always @(posedge clock) begin
      if (sink_stall != 0) begin
         sink_stall <= sink_stall - 1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         sink_stall <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one item, after an optional idle burst, and waits until it is taken.
   task send_tick(input i2cm_item_type it);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.req_type;
      req_tdata <= {6'd0, it.sda_in, it.read_ack, it.write_byte};
      do @(posedge clock); while (!req_tready);
   endtask

   // Issues one command, then plain ticks; with hold the command is repeated
   // on every tick so that it also arrives while busy and on completion.
   task run_window(input logic [2:0] kind, input logic [7:0] byte_val,
                   input logic ack_val, input int sda_high_pct, input bit hold,
                   input int n);
      i2cm_item_type it;
      for (int i = 0; i < n; i++) begin
         it.req_type = (i == 0 || hold) ? kind : REQ_NONE;
         it.write_byte = byte_val;
         it.read_ack = ack_val;
         it.sda_in = ($urandom_range(1, 100) <= sda_high_pct);
         send_tick(it);
      end
   endtask

   // Random ticks: any request code, any byte, SDA high with a given bias.
   task run_random(input int n, input int sda_high_pct);
      i2cm_item_type it;
      for (int i = 0; i < n; i++) begin
         it.req_type = ($urandom_range(0, 3) == 0) ? REQ_NONE : 3'($urandom_range(0, 7));
         it.write_byte = 8'($urandom);
         it.read_ack = 1'($urandom);
         it.sda_in = ($urandom_range(1, 100) <= sda_high_pct);
         send_tick(it);
      end
   endtask

   // Stops offering items and waits until every result has come back.
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task set_config(input logic [15:0] phase_ticks, input logic [7:0] poll_limit);
      csr_we <= 1'b1;
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= phase_ticks;
      @(posedge clock);
      csr_index <= CSR_POLL_LIMIT;
      csr_wdata <= {8'($urandom), poll_limit};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int          sda_pct;
      logic [7:0]  poll_limit;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A start with the register values from reset.
      run_window(REQ_START, 8'h00, 1'b0, 100, 1'b0, 50);

      // Directed commands with one tick per phase and a short ack poll.
      drain();
      set_config(16'd1, 8'd3);
      run_window(REQ_WRITE, 8'hFF, 1'b0, 0, 1'b0, 48);
      run_window(REQ_WRITE, 8'h00, 1'b1, 100, 1'b0, 48);
      run_window(REQ_WRITE, 8'hA5, 1'b0, 70, 1'b0, 48);
      run_window(REQ_READ, 8'h00, 1'b1, 100, 1'b0, 48);
      run_window(REQ_READ, 8'hFF, 1'b0, 0, 1'b0, 48);
      run_window(REQ_READ, 8'h5A, 1'b1, 50, 1'b0, 48);
      run_window(REQ_STOP, 8'h00, 1'b0, 50, 1'b0, 48);
      run_window(REQ_RESERVED_LO, 8'hFF, 1'b1, 50, 1'b0, 4);
      run_window(REQ_RESERVED_HI, 8'hFF, 1'b1, 50, 1'b0, 4);
      run_window(REQ_NONE, 8'hFF, 1'b1, 50, 1'b0, 4);
      run_window(REQ_START, 8'h00, 1'b0, 50, 1'b1, 20);
      run_window(REQ_WRITE, 8'h3C, 1'b1, 50, 1'b1, 48);

      // Zero phase length and a zero poll limit, which wraps to 256 polls.
      drain();
      set_config(16'd0, 8'd0);
      run_window(REQ_WRITE, 8'h81, 1'b0, 100, 1'b0, 300);
      run_window(REQ_READ, 8'h00, 1'b0, 50, 1'b0, 30);

      // Random ticks under a few short settings, with and without idling.
      for (int p = 0; p < 6; p++) begin
         drain();
         idling = (p % 2 == 0);
         case ($urandom_range(0, 3))
            0: poll_limit = 8'd255;
            1: poll_limit = 8'd0;
            default: poll_limit = 8'($urandom_range(2, 12));
         endcase
         if (p == 0) poll_limit = 8'd1;
         case ($urandom_range(0, 2))
            0: sda_pct = 50;
            1: sda_pct = 85;
            default: sda_pct = 100;
         endcase
         set_config(16'($urandom_range(0, 4)), poll_limit);
         run_random(140, sda_pct);
      end

      // Longest phase length: a start whose first phase is still counting
      // down at the end; no idling from here on.
      drain();
      idling = 1'b0;
      set_config(16'hFFFF, 8'hFF);
      run_window(REQ_START, 8'h00, 1'b0, 50, 1'b0, 16);

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
